/* hw/rtl/pre_pkg.sv */
// Package for the permutation register engine: sizes, opcodes, status codes,
// controller states and the command/status structs. No dependencies.
package pre_pkg;

  localparam int MaxSize = 16;
  localparam int IdxW    = $clog2(MaxSize);
  localparam int CntW    = $clog2(MaxSize + 1);

  typedef enum logic [2:0] {
    OP_NEXT     = 3'd0,
    OP_SORT     = 3'd1,
    OP_REVERSE  = 3'd2,
    OP_MOVE     = 3'd3,
    OP_READ     = 3'd4,
    OP_IDENTITY = 3'd5,
    OP_BAD6     = 3'd6,
    OP_BAD7     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LAST  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SPARE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NX_SCAN,
    S_NX_FIND,
    S_NX_SWAP,
    S_REV,
    S_SORT_OUT,
    S_SORT_IN,
    S_MOVE,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;      // capture the request indices
    logic            ident;     // load identity into the whole store
    logic            swap;      // swap entries at ptr_a and ptr_b
    logic            set_ij;    // ptr_a <- first, ptr_b <- last
    logic            dec_b;     // ptr_b <- ptr_b - 1
    logic            inc_a;     // ptr_a <- ptr_a + 1
    logic            dec_a;     // ptr_a <- ptr_a - 1
    logic            piv_set;   // ptr_a <- ptr_b - 1, best <- ptr_b, k <- ptr_b + 1
    logic            k_step;    // consider entry k against the best so far
    logic            to_rev;    // ptr_a <- ptr_a + 1, ptr_b <- last (after pivot swap)
    logic            sort_init; // outer <- first + 2, ptr_a <- first, ptr_b <- first + 1
    logic            sort_next; // outer++, ptr_a <- outer - 1, ptr_b <- outer
    logic            mv_init;   // with load: ptr_b starts next to first, towards last
    logic            mv_step;   // ptr_a <- ptr_b, ptr_b <- next entry towards last
    logic            swap_best; // ptr_b <- best before the pivot swap
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_lt_b;      // ptr_a < ptr_b
    logic scan_more;   // ptr_b > first + 1 and entry[ptr_b-1] > entry[ptr_b]
    logic is_last;     // ptr_b == first + 1 and entry[first] > entry[first+1]
    logic k_more;      // k <= last
    logic sort_swap;   // ptr_b > first and entry[ptr_b-1] < entry[ptr_b]
    logic outer_more;  // outer <= last
    logic mv_more;     // move pointer has not reached destination
  } dp_stat_t;

endpackage

/* hw/rtl/pre_datapath.sv */
// Datapath of the permutation register engine: the permutation store,
// pointer registers and comparators. Depends on pre_pkg and pre_mover.
module pre_datapath (
  input  logic                      clk,
  input  logic [pre_pkg::IdxW-1:0]  first_index,
  input  logic [pre_pkg::IdxW-1:0]  last_index,
  input  pre_pkg::dp_cmd_t          cmd,
  output pre_pkg::dp_stat_t         stat,
  input  logic                      rst,
  output logic [pre_pkg::IdxW-1:0]  read_value
);

  logic [pre_pkg::IdxW-1:0] store [pre_pkg::MaxSize];
  logic [pre_pkg::IdxW-1:0] first, last, ptr_a, ptr_b, best;
  logic [pre_pkg::CntW-1:0] k, outer;
  logic [pre_pkg::IdxW-1:0] ent_a, ent_b, ent_bm1, ent_k, ent_best, ent_f, ent_f1;
  logic [pre_pkg::IdxW-1:0] kidx, bm1;
  logic [pre_pkg::CntW-1:0] first_p1, ptr_b_w;
  logic                     mv_up;
  logic [pre_pkg::IdxW-1:0] mv_nbr, mv_start;

  assign bm1      = ptr_b - 1'b1;
  assign kidx     = k[pre_pkg::IdxW-1:0];
  assign ent_a    = store[ptr_a];
  assign ent_b    = store[ptr_b];
  assign ent_bm1  = store[bm1];
  assign ent_k    = store[kidx];
  assign ent_best = store[best];
  assign ent_f    = store[first];
  assign ent_f1   = store[first + 1'b1];
  assign first_p1 = {1'b0, first} + 1'b1;
  assign ptr_b_w  = {1'b0, ptr_b};
  assign read_value = store[first_index];
  assign mv_start = (first_index < last_index) ? first_index + 1'b1 : first_index - 1'b1;

  // During a move ptr_b stays one entry ahead of ptr_a towards the destination.
  pre_mover u_mover (
    .up(mv_up), .ptr(ptr_b), .nbr(mv_nbr)
  );

  assign stat.a_lt_b     = ptr_a < ptr_b;
  assign stat.scan_more  = (ptr_b_w > first_p1) && (ent_bm1 > ent_b);
  assign stat.is_last    = (ptr_b_w == first_p1) && (ent_f > ent_f1);
  assign stat.k_more     = k <= {1'b0, last};
  assign stat.sort_swap  = (ptr_b > first) && (ent_bm1 < ent_b);
  assign stat.outer_more = outer <= {1'b0, last};
  assign stat.mv_more    = ptr_a != last;

  always_ff @(posedge clk) begin
    if (rst || cmd.ident) begin
      for (int i = 0; i < pre_pkg::MaxSize; i++) begin
        store[i] <= pre_pkg::IdxW'(i);
      end
    end else if (cmd.swap) begin
      store[ptr_a] <= ent_b;
      store[ptr_b] <= ent_a;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first <= first_index;
      last  <= last_index;
      mv_up <= first_index < last_index;
      ptr_a <= first_index;
      ptr_b <= cmd.mv_init ? mv_start : last_index;
    end
    if (cmd.set_ij) begin
      ptr_a <= first;
      ptr_b <= last;
    end
    if (cmd.dec_b) begin
      ptr_b <= bm1;
    end
    if (cmd.inc_a) begin
      ptr_a <= ptr_a + 1'b1;
    end
    if (cmd.dec_a) begin
      ptr_a <= ptr_a - 1'b1;
    end
    if (cmd.piv_set) begin
      ptr_a <= bm1;
      best  <= ptr_b;
      k     <= ptr_b_w + 1'b1;
    end
    if (cmd.k_step) begin
      if ((ent_a < ent_k) && (ent_k < ent_best)) begin
        best <= kidx;
      end
      k <= k + 1'b1;
    end
    if (cmd.swap_best) begin
      ptr_b <= best;
    end
    if (cmd.to_rev) begin
      ptr_a <= ptr_a + 1'b1;
      ptr_b <= last;
    end
    if (cmd.sort_init) begin
      outer <= first_p1 + 1'b1;
      ptr_a <= first;
      ptr_b <= first + 1'b1;
    end
    if (cmd.sort_next) begin
      outer <= outer + 1'b1;
      ptr_a <= outer[pre_pkg::IdxW-1:0] - 1'b1;
      ptr_b <= outer[pre_pkg::IdxW-1:0];
    end
    if (cmd.mv_step) begin
      ptr_a <= ptr_b;
      ptr_b <= mv_nbr;
    end
  end

endmodule

/* hw/rtl/pre_control.sv */
// Controller state machine of the permutation register engine: decodes a
// request, sequences the datapath and issues the result. Depends on pre_pkg.
module pre_control (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [2:0]                opcode,
  input  logic [pre_pkg::IdxW-1:0]  first_index,
  input  logic [pre_pkg::IdxW-1:0]  last_index,
  input  logic [pre_pkg::CntW-1:0]  size,
  input  pre_pkg::dp_stat_t         stat,
  input  logic [pre_pkg::IdxW-1:0]  read_value,
  output pre_pkg::dp_cmd_t          cmd,
  output logic                      busy,
  output logic                      done,
  output logic [1:0]                status,
  output logic [3:0]                element_value
);

  pre_pkg::state_t state, state_next;
  pre_pkg::status_t res, res_next;
  logic [3:0] value, value_next;
  logic a_bad, b_bad;

  assign a_bad = {1'b0, first_index} >= size;
  assign b_bad = {1'b0, last_index} >= size;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pre_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
    res   <= res_next;
    value <= value_next;
  end

  assign busy = state != pre_pkg::S_IDLE;
  assign done = state == pre_pkg::S_DONE;
  assign status = res;
  assign element_value = done ? value : 4'd0;

  always_comb begin
    state_next = state;
    res_next   = res;
    value_next = value;
    cmd        = '0;
    unique case (state)
      pre_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          res_next   = pre_pkg::ST_OK;
          value_next = 4'd0;
          state_next = pre_pkg::S_DONE;
          unique case (pre_pkg::opcode_t'(opcode))
            pre_pkg::OP_NEXT: begin
              if (b_bad) res_next = pre_pkg::ST_RANGE;
              else if (last_index <= first_index) res_next = pre_pkg::ST_LAST;
              else state_next = pre_pkg::S_NX_SCAN;
            end
            pre_pkg::OP_SORT: begin
              if (a_bad || b_bad) res_next = pre_pkg::ST_RANGE;
              else if (first_index < last_index) state_next = pre_pkg::S_SORT_OUT;
            end
            pre_pkg::OP_REVERSE: begin
              if (a_bad || b_bad) res_next = pre_pkg::ST_RANGE;
              else state_next = pre_pkg::S_REV;
            end
            pre_pkg::OP_MOVE: begin
              if (a_bad || b_bad) res_next = pre_pkg::ST_RANGE;
              else if (first_index != last_index) begin
                cmd.mv_init = 1'b1;
                state_next  = pre_pkg::S_MOVE;
              end
            end
            pre_pkg::OP_READ: begin
              if (a_bad) res_next = pre_pkg::ST_RANGE;
              else value_next = read_value;
            end
            pre_pkg::OP_IDENTITY: cmd.ident = 1'b1;
            pre_pkg::OP_BAD6, pre_pkg::OP_BAD7: res_next = pre_pkg::ST_RANGE;
            default: res_next = pre_pkg::ST_RANGE;
          endcase
        end
      end
      pre_pkg::S_NX_SCAN: begin
        // Walk ptr_b down over the decreasing tail.
        if (stat.scan_more) begin
          cmd.dec_b = 1'b1;
        end else if (stat.is_last) begin
          res_next   = pre_pkg::ST_LAST;
          state_next = pre_pkg::S_DONE;
        end else begin
          cmd.piv_set = 1'b1;
          state_next  = pre_pkg::S_NX_FIND;
        end
      end
      pre_pkg::S_NX_FIND: begin
        if (stat.k_more) begin
          cmd.k_step = 1'b1;
        end else begin
          cmd.swap_best = 1'b1;
          state_next    = pre_pkg::S_NX_SWAP;
        end
      end
      pre_pkg::S_NX_SWAP: begin
        cmd.swap   = 1'b1;
        cmd.to_rev = 1'b1;
        state_next = pre_pkg::S_REV;
      end
      pre_pkg::S_REV: begin
        if (stat.a_lt_b) begin
          cmd.swap  = 1'b1;
          cmd.inc_a = 1'b1;
          cmd.dec_b = 1'b1;
        end else begin
          state_next = pre_pkg::S_DONE;
        end
      end
      pre_pkg::S_SORT_OUT: begin
        cmd.sort_init = 1'b1;
        state_next    = pre_pkg::S_SORT_IN;
      end
      pre_pkg::S_SORT_IN: begin
        // Insertion sort: bubble entry ptr_b towards first while smaller on the left.
        if (stat.sort_swap) begin
          cmd.swap  = 1'b1;
          cmd.dec_a = 1'b1;
          cmd.dec_b = 1'b1;
        end else if (stat.outer_more) begin
          cmd.sort_next = 1'b1;
        end else begin
          state_next = pre_pkg::S_DONE;
        end
      end
      pre_pkg::S_MOVE: begin
        if (stat.mv_more) begin
          cmd.swap    = 1'b1;
          cmd.mv_step = 1'b1;
        end else begin
          state_next = pre_pkg::S_DONE;
        end
      end
      pre_pkg::S_DONE: state_next = pre_pkg::S_IDLE;
      default: state_next = pre_pkg::S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/pre_mover.sv */
// Move-step helper: derives the neighbour pointer for a move by adjacent
// swaps, so the datapath swaps ptr_a with the next entry towards the destination.
module pre_mover (
  input  logic                     up,
  input  logic [pre_pkg::IdxW-1:0] ptr,
  output logic [pre_pkg::IdxW-1:0] nbr
);
  assign nbr = up ? ptr + 1'b1 : ptr - 1'b1;
endmodule

/* hw/rtl/permutation_register_engine_core.sv */
// Top level of the permutation register engine: APB register, controller
// and datapath. Depends on pre_pkg, pre_control and pre_datapath.
//
// Usage: write active_size (byte address 0) over the APB port while idle.
// Issue a request by raising start with opcode, first_index and last_index;
// it is taken at an edge where start is high and busy is low. busy stays
// high until the result; done pulses for one cycle with status and
// element_value, and the receiver cannot hold it off.
// Read, identity, errors and trivial ranges of next permutation, sort and
// move go from the accepted request straight to done; the other requests
// step through the datapath, which has a single swap port on the store:
// one swap or compare per cycle. One request is worked at a time, and the
// next can be taken in the cycle after done.
// Reset loads the identity permutation and an active size of sixteen.
module permutation_register_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [2:0]  opcode,
  input  logic [3:0]  first_index,
  input  logic [3:0]  last_index,
  output logic [1:0]  status,
  output logic [3:0]  element_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] active_size;
  logic [pre_pkg::CntW-1:0] size;
  pre_pkg::dp_cmd_t cmd;
  pre_pkg::dp_stat_t stat;
  logic [pre_pkg::IdxW-1:0] read_value;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, active_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= 5'd16;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      active_size <= pwdata[4:0];
    end
  end

  always_comb begin
    if (active_size == 5'd0) size = 5'd1;
    else if (active_size > 5'd16) size = 5'd16;
    else size = active_size;
  end

  pre_control u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode),
    .first_index(first_index), .last_index(last_index), .size(size),
    .stat(stat), .read_value(read_value), .cmd(cmd), .busy(busy),
    .done(done), .status(status), .element_value(element_value)
  );

  pre_datapath u_dp (
    .clk(clk), .rst(rst), .first_index(first_index), .last_index(last_index),
    .cmd(cmd), .stat(stat), .read_value(read_value)
  );

endmodule
